// ===== hdl/tfat_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the TLB address translator.
// No dependencies.
package tfat_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;
    localparam int VA_BITS     = 16;
    localparam int INDEX_BITS  = 8;
    localparam int CNT_BITS    = 32;
    localparam int TABLE_DEPTH = 1 << PAGE_BITS;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] tag;
        logic [PAGE_BITS-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic                 hit;
        logic [PAGE_BITS-1:0] frame;
    } t_match;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// ===== hdl/tlb_fifo_address_translator_top.sv =====
`timescale 1ns / 1ps
// Translates virtual addresses through a fully associative TLB held in a
// chain of entry cells, filled first-in first-out, backed by a page table
// RAM. A translate beat holds busy high for one cycle after it is taken,
// in the lookup state, and its result is registered from that state and
// strobes o_valid for one cycle; no new request is taken during the lookup,
// which waits on the registered page-table read started at acceptance. A
// page-table write leaves busy low and gives no result. The receiver cannot
// stall: each result is valid for exactly one cycle, while the next request
// may already be taken. Uses tfat_pkg, tfat_ram and tfat_cell.
module tlb_fifo_address_translator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [tfat_pkg::VA_BITS-1:0]    i_virtual_address,
    input  logic [tfat_pkg::INDEX_BITS-1:0] i_entry_index,
    input  logic [tfat_pkg::INDEX_BITS-1:0] i_entry_frame,
    output logic                            o_valid,
    output logic [tfat_pkg::VA_BITS-1:0]    o_physical_address,
    output logic                            o_tlb_hit,
    output logic [tfat_pkg::CNT_BITS-1:0]   o_hit_total,
    output logic [tfat_pkg::CNT_BITS-1:0]   o_miss_total
);
    import tfat_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [PAGE_BITS-1:0]   r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_valid;
    logic [VA_BITS-1:0]     r_pa;
    logic                   r_hit;
    logic [CNT_BITS-1:0]    r_hit_cnt;
    logic [CNT_BITS-1:0]    r_miss_cnt;

    logic                 accept;
    logic                 take_xlate;
    logic                 pt_we;
    logic                 lookup;
    logic                 shift;
    logic [PAGE_BITS-1:0] pt_rdata;
    logic [PAGE_BITS-1:0] frame;

    t_entry entry_chain [TLB_ENTRIES+1];
    t_match match_chain [TLB_ENTRIES+1];
    logic [TLB_ENTRIES-1:0] valid_vec;

    assign accept     = start && !busy;
    assign take_xlate = accept && (i_op == OP_TRANSLATE);
    assign pt_we      = accept && (i_op == OP_WRITE);

    tfat_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_page_table (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (i_entry_index[PAGE_BITS-1:0]),
        .i_wdata (i_entry_frame[PAGE_BITS-1:0]),
        .i_raddr (i_virtual_address[OFFSET_BITS +: PAGE_BITS]),
        .o_rdata (pt_rdata)
    );

    // new entries enter at cell 0, the oldest drops off the end
    assign entry_chain[0] = '{valid: 1'b1, tag: r_page, frame: pt_rdata};
    assign match_chain[0] = '{hit: 1'b0, frame: '0};

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        tfat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry (entry_chain[g]),
            .o_entry (entry_chain[g+1]),
            .i_page  (r_page),
            .i_match (match_chain[g]),
            .o_match (match_chain[g+1])
        );
        assign valid_vec[g] = entry_chain[g+1].valid;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take_xlate) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        lookup = 1'b0;
        case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_LOOKUP: begin
                busy   = 1'b1;
                lookup = 1'b1;
            end
            default:   busy = 1'b0;
        endcase
    end

    assign shift = lookup && !match_chain[TLB_ENTRIES].hit;
    assign frame = match_chain[TLB_ENTRIES].hit ? match_chain[TLB_ENTRIES].frame : pt_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= lookup;
            if (lookup && match_chain[TLB_ENTRIES].hit && (r_hit_cnt != '1)) begin
                r_hit_cnt <= r_hit_cnt + 1'b1;
            end
            if (shift && (r_miss_cnt != '1)) begin
                r_miss_cnt <= r_miss_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_xlate) begin
            r_page   <= i_virtual_address[OFFSET_BITS +: PAGE_BITS];
            r_offset <= i_virtual_address[OFFSET_BITS-1:0];
        end
        if (lookup) begin
            r_pa  <= VA_BITS'({frame, r_offset});
            r_hit <= match_chain[TLB_ENTRIES].hit;
        end
    end

    assign o_valid            = r_valid;
    assign o_physical_address = r_pa;
    assign o_tlb_hit          = r_hit;
    assign o_hit_total        = r_hit_cnt;
    assign o_miss_total       = r_miss_cnt;

`ifndef SYNTHESIS
    a_one_cycle_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("lookup held longer than one cycle");

    a_result_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    a_hit_keeps_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tlb_hit) |-> (o_miss_total == $past(o_miss_total)))
        else $error("miss count moved on a hit");

    a_miss_keeps_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tlb_hit) |-> (o_hit_total == $past(o_hit_total)))
        else $error("hit count moved on a miss");

    a_valid_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(valid_vec + 1'b1))
        else $error("TLB valid bits not filled from the front");
`endif

endmodule

// ===== hdl/tfat_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tfat_cell.sv =====
`timescale 1ns / 1ps
// One TLB entry of the shift chain: holds an entry, compares its tag and
// passes the match result and, on a fill, its entry to the next cell. Uses tfat_pkg.
module tfat_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  tfat_pkg::t_entry              i_entry,
    output tfat_pkg::t_entry              o_entry,
    input  logic [tfat_pkg::PAGE_BITS-1:0] i_page,
    input  tfat_pkg::t_match              i_match,
    output tfat_pkg::t_match              o_match
);
    import tfat_pkg::*;

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_tag;
    logic [PAGE_BITS-1:0] r_frame;
    logic                 own_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag   <= i_entry.tag;
            r_frame <= i_entry.frame;
        end
    end

    assign own_hit = r_valid && (r_tag == i_page);

    // earlier cell wins
    always_comb begin
        if (i_match.hit) begin
            o_match = i_match;
        end else begin
            o_match.hit   = own_hit;
            o_match.frame = r_frame;
        end
    end

    assign o_entry = '{valid: r_valid, tag: r_tag, frame: r_frame};

endmodule

// ===== test/tlb_fifo_address_translator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tlb_fifo_address_translator_top: page-table writes and
// translates go in from a queue, and each result is compared with a local TLB model.
// Depends on tfat_pkg and the translator RTL.
module tlb_fifo_address_translator_top_tb;
    import tfat_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int IDLE_LIMIT  = 200;
    localparam int PLAN_BEATS  = 1250;
    localparam int SLOT_BITS   = $clog2(TLB_ENTRIES);

    typedef struct {
        bit                    drain;
        logic                  op;
        logic [VA_BITS-1:0]    va;
        logic [INDEX_BITS-1:0] idx;
        logic [INDEX_BITS-1:0] frm;
        int                    gap_after;
    } t_beat;

    typedef struct {
        logic [VA_BITS-1:0]  pa;
        logic                hit;
        logic [CNT_BITS-1:0] hits;
        logic [CNT_BITS-1:0] misses;
    } t_xlat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_op = OP_TRANSLATE;
    logic [VA_BITS-1:0]    i_virtual_address = '0;
    logic [INDEX_BITS-1:0] i_entry_index = '0;
    logic [INDEX_BITS-1:0] i_entry_frame = '0;
    logic                  o_valid;
    logic [VA_BITS-1:0]    o_physical_address;
    logic                  o_tlb_hit;
    logic [CNT_BITS-1:0]   o_hit_total;
    logic [CNT_BITS-1:0]   o_miss_total;

    tlb_fifo_address_translator_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_virtual_address  (i_virtual_address),
        .i_entry_index      (i_entry_index),
        .i_entry_frame      (i_entry_frame),
        .o_valid            (o_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_hit_total        (o_hit_total),
        .o_miss_total       (o_miss_total)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // local copy of translator state
    logic [PAGE_BITS-1:0] tlb_tag   [TLB_ENTRIES];
    logic                 tlb_live  [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame [TLB_ENTRIES];
    logic [SLOT_BITS-1:0] fill_slot;
    logic [PAGE_BITS-1:0] frame_table [TABLE_DEPTH];
    logic [CNT_BITS-1:0]  hit_count;
    logic [CNT_BITS-1:0]  miss_count;

    t_beat pending_beats[$];
    t_xlat xlat_due[$];
    bit    page_known [TABLE_DEPTH];
    int    known_pages[$];
    int    planned_beats;

    int issued_beats;
    int accepted_beats;
    int gap_left;
    bit draining;
    int idle_cycles;
    int error_count;
    int seen_hits;
    int seen_misses;
    int writes_taken;

    initial begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_tag[i]   = '0;
            tlb_live[i]  = 1'b0;
            tlb_frame[i] = '0;
        end
        fill_slot  = '0;
        hit_count  = '0;
        miss_count = '0;
    end

    task automatic predict_translation(input logic [VA_BITS-1:0] va);
        logic [PAGE_BITS-1:0] page;
        logic [PAGE_BITS-1:0] frame;
        logic                 hit;
        t_xlat                res;
        page  = va[VA_BITS-1:OFFSET_BITS];
        frame = '0;
        hit   = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && tlb_live[i] && tlb_tag[i] == page) begin
                hit   = 1'b1;
                frame = tlb_frame[i];
            end
        end
        if (hit) begin
            if (hit_count != '1) hit_count = hit_count + 1'b1;
        end else begin
            frame = frame_table[page];
            tlb_tag[fill_slot]   = page;
            tlb_frame[fill_slot] = frame;
            tlb_live[fill_slot]  = 1'b1;
            fill_slot = (fill_slot == SLOT_BITS'(TLB_ENTRIES - 1)) ? '0 : fill_slot + 1'b1;
            if (miss_count != '1) miss_count = miss_count + 1'b1;
        end
        res.pa     = {frame, va[OFFSET_BITS-1:0]};
        res.hit    = hit;
        res.hits   = hit_count;
        res.misses = miss_count;
        xlat_due.push_back(res);
    endtask

    function automatic void plan_write(input int idx, input int frm, input int gap);
        t_beat                 b;
        logic [INDEX_BITS-1:0] page;
        page        = INDEX_BITS'(idx);
        b.drain     = 1'b0;
        b.op        = OP_WRITE;
        b.va        = VA_BITS'($urandom_range(0, 16'hFFFF));
        b.idx       = page;
        b.frm       = INDEX_BITS'(frm);
        b.gap_after = gap;
        pending_beats.push_back(b);
        if (!page_known[page]) begin
            page_known[page] = 1'b1;
            known_pages.push_back(idx);
        end
        planned_beats++;
    endfunction

    function automatic void plan_translate(input int va, input int gap);
        t_beat b;
        b.drain     = 1'b0;
        b.op        = OP_TRANSLATE;
        b.va        = VA_BITS'(va);
        b.idx       = INDEX_BITS'($urandom_range(0, 255));
        b.frm       = INDEX_BITS'($urandom_range(0, 255));
        b.gap_after = gap;
        pending_beats.push_back(b);
        planned_beats++;
    endfunction

    function automatic void plan_drain();
        t_beat b;
        b.drain     = 1'b1;
        b.op        = OP_TRANSLATE;
        b.va        = '0;
        b.idx       = '0;
        b.frm       = '0;
        b.gap_after = 0;
        pending_beats.push_back(b);
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && accepted_beats != issued_beats) begin
            // hold until taken
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (draining) begin
            start <= 1'b0;
            if (xlat_due.size() == 0) draining <= 1'b0;
        end else if (pending_beats.size() == 0) begin
            start <= 1'b0;
        end else begin
            b = pending_beats.pop_front();
            if (b.drain) begin
                start    <= 1'b0;
                draining <= 1'b1;
            end else begin
                i_op              <= b.op;
                i_virtual_address <= b.va;
                i_entry_index     <= b.idx;
                i_entry_frame     <= b.frm;
                start             <= 1'b1;
                issued_beats      <= issued_beats + 1;
                gap_left          <= b.gap_after;
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_xlat exp_res;
        bit    active;
        if (i_rst_n) begin
            active = 1'b0;
            if (o_valid) begin
                active = 1'b1;
                if (xlat_due.size() == 0) begin
                    $error("result beat with nothing expected: pa=%h", o_physical_address);
                    error_count++;
                end else begin
                    exp_res = xlat_due.pop_front();
                    if (o_physical_address !== exp_res.pa) begin
                        $error("physical_address: expected %h, got %h",
                               exp_res.pa, o_physical_address);
                        error_count++;
                    end
                    if (o_tlb_hit !== exp_res.hit) begin
                        $error("tlb_hit: expected %b, got %b", exp_res.hit, o_tlb_hit);
                        error_count++;
                    end
                    if (o_hit_total !== exp_res.hits) begin
                        $error("hit_total: expected %0d, got %0d", exp_res.hits, o_hit_total);
                        error_count++;
                    end
                    if (o_miss_total !== exp_res.misses) begin
                        $error("miss_total: expected %0d, got %0d",
                               exp_res.misses, o_miss_total);
                        error_count++;
                    end
                    if (exp_res.hit) seen_hits++;
                    else seen_misses++;
                end
            end
            if (start && !busy) begin
                active = 1'b1;
                accepted_beats <= accepted_beats + 1;
                if (i_op == OP_WRITE) begin
                    frame_table[i_entry_index] = i_entry_frame;
                    writes_taken++;
                end else begin
                    predict_translation(i_virtual_address);
                end
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int hot[$];
        int hot_n;
        int gmax;
        int n;
        int r;
        int p;

        issued_beats   = 0;
        accepted_beats = 0;
        gap_left       = 0;
        draining       = 1'b0;
        idle_cycles    = 0;
        error_count    = 0;
        seen_hits      = 0;
        seen_misses    = 0;
        writes_taken   = 0;
        planned_beats  = 0;

        // directed: field extremes, hit after miss, stale TLB entry after rewrite
        plan_write(8'h00, 8'hFF, $urandom_range(0, 5));
        plan_write(8'hFF, 8'h00, $urandom_range(0, 5));
        plan_write(8'h5A, 8'hA5, 0);
        plan_write(8'hA5, 8'h5A, 0);
        plan_translate(16'h0000, 0);
        plan_translate(16'h00FF, 0);
        plan_translate(16'hFFFF, $urandom_range(0, 5));
        plan_translate(16'hFF00, 0);
        plan_translate(16'h5AA5, 1);
        plan_translate(16'hA55A, 0);
        plan_write(8'h00, 8'h3C, 0);
        plan_translate(16'h0081, 0);
        plan_drain();
        plan_translate(16'h00C3, 2);

        // random: bursts over a hot page set, sized around the TLB depth
        while (planned_beats < PLAN_BEATS) begin
            hot.delete();
            hot_n = $urandom_range(1, 24);
            gmax  = ($urandom_range(0, 3) == 0) ? 0 : 5;
            repeat (hot_n) begin
                p = $urandom_range(0, 255);
                hot.push_back(p);
                if (!page_known[p[PAGE_BITS-1:0]]) begin
                    plan_write(p, $urandom_range(0, 255), $urandom_range(0, gmax));
                end
            end
            n = $urandom_range(30, 80);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    p = (r < 6) ? hot[$urandom_range(0, hot.size() - 1)] : $urandom_range(0, 255);
                    plan_write(p, $urandom_range(0, 255), $urandom_range(0, gmax));
                end else if (r < 20) begin
                    p = known_pages[$urandom_range(0, known_pages.size() - 1)];
                    plan_translate((p << OFFSET_BITS) | $urandom_range(0, 255),
                                   $urandom_range(0, gmax));
                end else begin
                    p = hot[$urandom_range(0, hot.size() - 1)];
                    plan_translate((p << OFFSET_BITS) | $urandom_range(0, 255),
                                   $urandom_range(0, gmax));
                end
            end
            if ($urandom_range(0, 3) == 0) plan_drain();
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || accepted_beats != issued_beats || draining
               || xlat_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (xlat_due.size() != 0) begin
            $error("%0d translations never returned", xlat_due.size());
            error_count++;
        end
        $display("covered %0d beats: %0d page-table writes, %0d TLB hits, %0d misses",
                 accepted_beats, writes_taken, seen_hits, seen_misses);
        $display("hot sets of 1 to 24 pages exercised FIFO refill and stale entries after rewrite");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
